// ----- rtl/ajp_pkg.sv -----
// Package for the analog joystick port emulator.
// Holds command, config and phase codes, shared types and constants.
// No dependencies.
package ajp_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_AXIS   = 2'd2,
    CMD_BUTTON = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_MODE_SELECT  = 2'd0,
    CFG_PORT_ENABLE  = 2'd1,
    CFG_KEY_OVL_EN   = 2'd2,
    CFG_KEY_OVL_PORT = 2'd3
  } cfg_idx_e;

  // mode_select codes; the fourth code leaves the mode untouched
  localparam logic [1:0] MODE_DIGITAL = 2'd0;
  localparam logic [1:0] MODE_ANALOG  = 2'd1;
  localparam logic [1:0] MODE_AUTO    = 2'd2;

  // axis codes
  localparam logic [1:0] AXIS_VERT    = 2'd0;
  localparam logic [1:0] AXIS_HORIZ   = 2'd1;
  localparam logic [1:0] AXIS_TRIGGER = 2'd2;

  // analog handshake phases
  typedef enum logic [3:0] {
    PH_WAIT    = 4'd0,
    PH_HI_ACK  = 4'd1,
    PH_HI      = 4'd2,
    PH_HI_END  = 4'd3,
    PH_LO_ACK  = 4'd4,
    PH_LO      = 4'd5,
    PH_LO_END  = 4'd6,
    PH_PAIR    = 4'd7,
    PH_LOOP    = 4'd8
  } hs_phase_e;

  localparam int unsigned TableDepth = 13;
  localparam int unsigned TableRegs  = TableDepth - 1;  // last entry is constant zero
  localparam logic [3:0]  TableLast  = 4'd12;

  localparam logic [7:0] TableInit [TableDepth] = '{
    8'h9f, 8'hbf, 8'h97, 8'hb7, 8'h97, 8'hb7, 8'h9f, 8'hbf, 8'h9f, 8'hbf, 8'h9f, 8'hbf,
    8'h00
  };

  localparam logic [7:0]  AckBit       = 8'h40;
  localparam logic [7:0]  IdleByte     = 8'hdf;
  localparam logic [7:0]  LatchStrobe  = 8'hff;
  localparam logic [7:0]  PrefixLow    = 8'h90;
  localparam logic [7:0]  PrefixHigh   = 8'hb0;
  localparam logic [7:0]  FillerLo     = 8'hb7;
  localparam logic [7:0]  FillerHi     = 8'hbf;
  localparam logic [9:0]  DetectMax    = 10'd1000;
  localparam logic [9:0]  DetectAnalog = 10'd300;
  localparam logic [31:0] StartDelay   = 32'd40;

  // x/236 == (x>>2)/59; (x>>2) < 2^14, reciprocal 2^24/59 rounded up is exact there
  localparam logic [31:0] AxisRecip    = 32'd284360;
  localparam logic [7:0]  AxisDeadZone = 8'd5;
  localparam logic [7:0]  AxisPosMax   = 8'd127;
  localparam logic [7:0]  AxisNegMax   = 8'd128;
  localparam logic [7:0]  AxisCenter   = 8'd128;

  typedef struct packed {
    logic [1:0] mode_select;
    logic [1:0] port_enable_mask;
    logic       key_overlay_enable;
    logic       key_overlay_on_port1;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic        port;
    logic [7:0]  write_data;
    logic [31:0] now_us;
    logic [1:0]  axis_code;
    logic [15:0] axis_value;
    logic [3:0]  button_code;
    logic        pressed;
    logic [7:0]  key_overlay;
  } item_t;

  typedef struct packed {
    logic [3:0] byte_index;
    logic [3:0] handshake_phase;
  } status_t;

endpackage

// ----- rtl/ajp_axis.sv -----
// Axis scaler: signed 16-bit reading to offset-binary byte.
// Divide by 236 via reciprocal multiply, dead zone, clamp. Uses ajp_pkg.
module ajp_axis (
  input  logic [15:0] axis_value_i,
  output logic [7:0]  scaled_o
);

  logic        neg;
  logic [15:0] mag;
  logic [31:0] prod;
  logic [7:0]  quot;
  logic [7:0]  mag_dz;
  logic [7:0]  mag_cl;

  assign neg  = axis_value_i[15];
  // magnitude of -32768 is 0x8000, which still fits unsigned
  assign mag  = neg ? (16'd0 - axis_value_i) : axis_value_i;
  assign prod = 32'({18'd0, mag[15:2]}) * ajp_pkg::AxisRecip;
  assign quot = prod[31:24];

  always_comb begin
    mag_dz = (quot < ajp_pkg::AxisDeadZone) ? 8'd0 : (quot - ajp_pkg::AxisDeadZone);
    if (neg) begin
      mag_cl = (mag_dz > ajp_pkg::AxisNegMax) ? ajp_pkg::AxisNegMax : mag_dz;
    end else begin
      mag_cl = (mag_dz > ajp_pkg::AxisPosMax) ? ajp_pkg::AxisPosMax : mag_dz;
    end
  end

  assign scaled_o = neg ? (ajp_pkg::AxisCenter - mag_cl) : (ajp_pkg::AxisCenter + mag_cl);

endmodule

// ----- rtl/ajp_core.sv -----
// Per-transaction datapath and emulator state (status table, handshake, latches).
// Depends on ajp_pkg and ajp_axis.
module ajp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ajp_pkg::item_t    item_i,
  input  ajp_pkg::cfg_t     cfg_i,
  output logic [7:0]        read_data_o,
  output ajp_pkg::status_t  status_o
);

  logic [7:0]          tbl_q [ajp_pkg::TableRegs];
  logic [7:0]          tbl_d [ajp_pkg::TableRegs];
  logic                am_q, am_d;
  logic [9:0]          det_q, det_d;
  ajp_pkg::hs_phase_e  ph_q, ph_d;
  logic [3:0]          bidx_q, bidx_d;
  logic [31:0]         strobe_q, strobe_d;
  logic [7:0]          latch_q [2];
  logic [7:0]          latch_d [2];
  logic [7:0]          dlo_q, dlo_d;
  logic [7:0]          dhi_q, dhi_d;

  logic [7:0]  axis_u;
  logic [9:0]  det_inc;
  logic        am_rd;
  logic [9:0]  det_rd;
  logic [3:0]  bidx_g;
  logic [7:0]  tbl_b;
  logic [31:0] elapsed;
  logic        analog_rd;
  logic [7:0]  analog_r;
  logic [7:0]  dig_lo, dig_hi, dig_r;
  logic [7:0]  btn_lo, btn_hi, btn_s0, btn_s1, btn_s10;

  ajp_axis u_axis (
    .axis_value_i (item_i.axis_value),
    .scaled_o     (axis_u)
  );

  // mode decision on a port 0 read
  assign det_inc = (det_q < ajp_pkg::DetectMax) ? (det_q + 10'd1) : det_q;
  always_comb begin
    am_rd  = am_q;
    det_rd = det_q;
    case (cfg_i.mode_select)
      ajp_pkg::MODE_DIGITAL: am_rd = 1'b0;
      ajp_pkg::MODE_ANALOG:  am_rd = 1'b1;
      ajp_pkg::MODE_AUTO: begin
        det_rd = det_inc;
        if (det_inc >= ajp_pkg::DetectMax) am_rd = 1'b0;
      end
      default: ;
    endcase
  end

  assign analog_rd = (item_i.command == ajp_pkg::CMD_READ) && !item_i.port && am_rd;
  assign bidx_g    = (bidx_q > ajp_pkg::TableLast) ? ajp_pkg::TableLast : bidx_q;
  assign tbl_b     = (bidx_g == ajp_pkg::TableLast) ? ajp_pkg::TableInit[ajp_pkg::TableDepth-1]
                                                    : tbl_q[bidx_g];
  assign elapsed   = item_i.now_us - strobe_q;

  // handshake output byte
  always_comb begin
    case (ph_q)
      ajp_pkg::PH_WAIT:    analog_r = ajp_pkg::IdleByte;
      ajp_pkg::PH_HI_ACK,
      ajp_pkg::PH_HI_END,
      ajp_pkg::PH_LO_ACK,
      ajp_pkg::PH_LO_END:  analog_r = tbl_b | ajp_pkg::AckBit;
      ajp_pkg::PH_HI,
      ajp_pkg::PH_LO,
      ajp_pkg::PH_PAIR:    analog_r = tbl_b;
      default:             analog_r = (bidx_q < ajp_pkg::TableLast) ? tbl_b
                                                                    : ajp_pkg::IdleByte;
    endcase
  end

  // digital read: buttons muxed bitwise under the port latch
  always_comb begin
    dig_lo = 8'hff;
    dig_hi = 8'hff;
    if (cfg_i.port_enable_mask[item_i.port] && !item_i.port) begin
      dig_lo = dlo_q;
      dig_hi = dhi_q;
    end
    if (cfg_i.key_overlay_enable && (cfg_i.key_overlay_on_port1 == item_i.port)) begin
      dig_lo = dig_lo ^ item_i.key_overlay;
    end
    dig_r = (~latch_q[item_i.port] & dig_lo) | (latch_q[item_i.port] & dig_hi);
  end

  always_comb begin
    read_data_o = 8'd0;
    if (item_i.command == ajp_pkg::CMD_READ) begin
      read_data_o = analog_rd ? analog_r : dig_r;
    end
  end

  // button decode
  always_comb begin
    btn_lo  = 8'd0;
    btn_hi  = 8'd0;
    btn_s0  = 8'd0;
    btn_s1  = 8'd0;
    btn_s10 = 8'd0;
    case (item_i.button_code)
      4'd0:  btn_lo = 8'h01;
      4'd1:  btn_lo = 8'h02;
      4'd2:  btn_lo = 8'h04;
      4'd3:  btn_lo = 8'h08;
      4'd4:  begin btn_lo = 8'h20; btn_s0 = 8'h08; btn_s10 = 8'h08; end
      4'd5:  begin btn_lo = 8'h40; btn_s0 = 8'h04; btn_s10 = 8'h04; end
      4'd6:  begin btn_hi = 8'h04; btn_s0 = 8'h02; end
      4'd7:  begin btn_hi = 8'h08; btn_s0 = 8'h01; end
      4'd8:  btn_hi = 8'h01;
      4'd9:  btn_hi = 8'h02;
      4'd10: begin btn_hi = 8'h20; btn_s1 = 8'h08; end
      4'd11: begin btn_hi = 8'h40; btn_s1 = 8'h04; end
      4'd12: btn_s1 = 8'h02;
      4'd13: btn_s1 = 8'h01;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    am_d     = am_q;
    det_d    = det_q;
    ph_d     = ph_q;
    bidx_d   = bidx_q;
    strobe_d = strobe_q;
    latch_d  = latch_q;
    dlo_d    = dlo_q;
    dhi_d    = dhi_q;
    tbl_d    = tbl_q;
    case (item_i.command)
      ajp_pkg::CMD_READ: begin
        if (!item_i.port) begin
          am_d  = am_rd;
          det_d = det_rd;
        end
        if (analog_rd) begin
          case (ph_q)
            ajp_pkg::PH_WAIT: begin
              if (elapsed > ajp_pkg::StartDelay) ph_d = ajp_pkg::PH_HI_ACK;
            end
            ajp_pkg::PH_HI_ACK: ph_d = ajp_pkg::PH_HI;
            ajp_pkg::PH_HI:     ph_d = ajp_pkg::PH_HI_END;
            ajp_pkg::PH_HI_END: begin
              ph_d = ajp_pkg::PH_LO_ACK;
              if (bidx_q < ajp_pkg::TableLast) bidx_d = bidx_q + 4'd1;
            end
            ajp_pkg::PH_LO_ACK: ph_d = ajp_pkg::PH_LO;
            ajp_pkg::PH_LO:     ph_d = ajp_pkg::PH_LO_END;
            ajp_pkg::PH_LO_END: begin
              ph_d = ajp_pkg::PH_PAIR;
              if (bidx_q < ajp_pkg::TableLast) bidx_d = bidx_q + 4'd1;
            end
            ajp_pkg::PH_PAIR:   ph_d = ajp_pkg::PH_LOOP;
            default: begin
              if (bidx_q < ajp_pkg::TableLast) ph_d = ajp_pkg::PH_HI_ACK;
            end
          endcase
        end
      end
      ajp_pkg::CMD_WRITE: begin
        // falling strobe on port 0 restarts the transfer
        if (!item_i.port && (latch_q[0] == ajp_pkg::LatchStrobe) &&
            (item_i.write_data == 8'h00)) begin
          am_d     = (det_q > ajp_pkg::DetectAnalog);
          det_d    = 10'd0;
          bidx_d   = 4'd0;
          ph_d     = ajp_pkg::PH_WAIT;
          strobe_d = item_i.now_us;
        end
        latch_d[item_i.port] = item_i.write_data;
      end
      ajp_pkg::CMD_AXIS: begin
        case (item_i.axis_code)
          ajp_pkg::AXIS_VERT: begin
            tbl_d[2] = ajp_pkg::PrefixLow | {4'd0, axis_u[7:4]};
            tbl_d[6] = ajp_pkg::PrefixLow | {4'd0, axis_u[3:0]};
          end
          ajp_pkg::AXIS_HORIZ: begin
            tbl_d[3] = ajp_pkg::PrefixHigh | {4'd0, axis_u[7:4]};
            tbl_d[7] = ajp_pkg::PrefixHigh | {4'd0, axis_u[3:0]};
          end
          ajp_pkg::AXIS_TRIGGER: begin
            tbl_d[4] = ajp_pkg::PrefixLow | {4'd0, axis_u[7:4]};
            tbl_d[8] = ajp_pkg::PrefixLow | {4'd0, axis_u[3:0]};
          end
          default: ;
        endcase
        tbl_d[5]  = ajp_pkg::FillerLo;
        tbl_d[9]  = ajp_pkg::FillerHi;
        tbl_d[11] = ajp_pkg::FillerHi;
      end
      ajp_pkg::CMD_BUTTON: begin
        // active-low buttons: press clears, release sets
        if (item_i.pressed) begin
          dlo_d     = dlo_q & ~btn_lo;
          dhi_d     = dhi_q & ~btn_hi;
          tbl_d[0]  = (tbl_q[0] & ~btn_s0) | ajp_pkg::PrefixLow;
          tbl_d[1]  = (tbl_q[1] & ~btn_s1) | ajp_pkg::PrefixHigh;
          tbl_d[10] = (tbl_q[10] & ~btn_s10) | ajp_pkg::PrefixLow;
        end else begin
          dlo_d     = dlo_q | btn_lo;
          dhi_d     = dhi_q | btn_hi;
          tbl_d[0]  = tbl_q[0] | btn_s0 | ajp_pkg::PrefixLow;
          tbl_d[1]  = tbl_q[1] | btn_s1 | ajp_pkg::PrefixHigh;
          tbl_d[10] = tbl_q[10] | btn_s10 | ajp_pkg::PrefixLow;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ajp_pkg::TableRegs; i++) begin
        tbl_q[i] <= ajp_pkg::TableInit[i];
      end
      am_q       <= 1'b0;
      det_q      <= 10'd0;
      ph_q       <= ajp_pkg::PH_WAIT;
      bidx_q     <= 4'd0;
      strobe_q   <= 32'd0;
      latch_q[0] <= 8'd0;
      latch_q[1] <= 8'd0;
      dlo_q      <= 8'hff;
      dhi_q      <= 8'hff;
    end else if (en_i) begin
      tbl_q    <= tbl_d;
      am_q     <= am_d;
      det_q    <= det_d;
      ph_q     <= ph_d;
      bidx_q   <= bidx_d;
      strobe_q <= strobe_d;
      latch_q  <= latch_d;
      dlo_q    <= dlo_d;
      dhi_q    <= dhi_d;
    end
  end

  assign status_o.byte_index      = bidx_q;
  assign status_o.handshake_phase = ph_q;

endmodule

// ----- rtl/analog_joystick_port_emulator.sv -----
// Two-port joystick interface emulator, digital and analog handshake modes.
// Path from input transaction to result: input register, then result register.
// One transaction per cycle if not stalled; the shared state updates in a single pass.
// Reset: asynchronous active low; clears pipeline valids, restores config and state.
// Output register lets a new transaction enter while a result waits.
// Depends on ajp_pkg and ajp_core.
module analog_joystick_port_emulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic               port_i,
  input  logic [7:0]         write_data_i,
  input  logic [31:0]        now_us_i,
  input  logic [1:0]         axis_code_i,
  input  logic signed [15:0] axis_value_i,
  input  logic [3:0]         button_code_i,
  input  logic               pressed_i,
  input  logic [7:0]         key_overlay_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_data_o
);

  ajp_pkg::cfg_t    cfg_q;
  ajp_pkg::item_t   item_q;
  ajp_pkg::status_t status;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic [7:0]       rdata_q;
  logic [7:0]       core_rdata;
  logic             advance;
  logic             in_take;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_select          <= ajp_pkg::MODE_DIGITAL;
      cfg_q.port_enable_mask     <= 2'b01;
      cfg_q.key_overlay_enable   <= 1'b0;
      cfg_q.key_overlay_on_port1 <= 1'b0;
    end else if (cfg_we_i) begin
      case (ajp_pkg::cfg_idx_e'(cfg_index_i))
        ajp_pkg::CFG_MODE_SELECT:  cfg_q.mode_select          <= cfg_wdata_i;
        ajp_pkg::CFG_PORT_ENABLE:  cfg_q.port_enable_mask     <= cfg_wdata_i;
        ajp_pkg::CFG_KEY_OVL_EN:   cfg_q.key_overlay_enable   <= cfg_wdata_i[0];
        ajp_pkg::CFG_KEY_OVL_PORT: cfg_q.key_overlay_on_port1 <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command     <= ajp_pkg::cmd_e'(command_i);
      item_q.port        <= port_i;
      item_q.write_data  <= write_data_i;
      item_q.now_us      <= now_us_i;
      item_q.axis_code   <= axis_code_i;
      item_q.axis_value  <= axis_value_i;
      item_q.button_code <= button_code_i;
      item_q.pressed     <= pressed_i;
      item_q.key_overlay <= key_overlay_i;
    end
  end

  ajp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .read_data_o (core_rdata),
    .status_o    (status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= core_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled without both stages full");

  a_free_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("transaction did not reach the result register");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.byte_index <= ajp_pkg::TableLast)
    else $error("byte index past end of status table");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.handshake_phase <= 4'(ajp_pkg::PH_LOOP))
    else $error("handshake phase out of range");

endmodule
